// ----- design/b2b_pkg.sv -----
// Shared types, constants and helper functions of the BLAKE2b hash engine.
`default_nettype none
package b2b_pkg;

    // Item handed from the front end to the compression back end
    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  count;
        logic        last;
        logic        err;
    } cmd_t;

    // Result item
    typedef struct packed {
        logic [63:0] digest;
        logic        last;
        logic        err;
    } res_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_DIGEST_LEN    = 3'd0,
        CFG_KEY_LEN       = 3'd1,
        CFG_SALT_LOW      = 3'd2,
        CFG_SALT_HIGH     = 3'd3,
        CFG_PERSONAL_LOW  = 3'd4,
        CFG_PERSONAL_HIGH = 3'd5
    } cfg_idx_t;

    // Working vector indexes of one G function
    typedef struct packed {
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] c;
        logic [3:0] d;
    } g_idx_t;

    localparam logic [63:0] IV [0:7] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [3:0] SIGMA [0:9][0:15] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
    };

    localparam int unsigned ROUNDS = 12;
    localparam logic [7:0] BLOCK_BYTES = 8'd128;

    // Column and diagonal index sets of the eight G steps in a round
    function automatic g_idx_t g_index(input logic [2:0] g);
        g_idx_t r;
        unique case (g)
            3'd0: r = '{4'd0, 4'd4, 4'd8,  4'd12};
            3'd1: r = '{4'd1, 4'd5, 4'd9,  4'd13};
            3'd2: r = '{4'd2, 4'd6, 4'd10, 4'd14};
            3'd3: r = '{4'd3, 4'd7, 4'd11, 4'd15};
            3'd4: r = '{4'd0, 4'd5, 4'd10, 4'd15};
            3'd5: r = '{4'd1, 4'd6, 4'd11, 4'd12};
            3'd6: r = '{4'd2, 4'd7, 4'd8,  4'd13};
            3'd7: r = '{4'd3, 4'd4, 4'd9,  4'd14};
            default: r = '0;
        endcase
        return r;
    endfunction

    // Rotate right by a constant amount
    function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // Keep the low bytes below cnt, zero the rest
    function automatic logic [63:0] keep_bytes(input logic [63:0] x, input logic [3:0] cnt);
        logic [63:0] r;
        r = x;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) >= cnt)
            begin
                r[8*i +: 8] = 8'h00;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- design/blake2b_hash_engine.sv -----
// A message word is taken from the queue into the block buffer while the sequencer is idle.
// A word landing on a full buffer first costs one compression
// (counter update, vector load, 12 rounds x 16 half-G steps, chain update).
// A last word ends in a final compression, digest output (held while results are full) and re-init.
// A single half-G datapath sets the rate on long messages; no words are taken during a compression.
// Reset: control and configuration registers clear, digest length to 64; the chain loads in ST_INIT.
// Top level of the BLAKE2b hash engine.
`default_nettype none
module blake2b_hash_engine #(
    parameter int unsigned CMD_DEPTH = 2,
    parameter int unsigned RES_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [63:0] data_word,
    input  wire logic [3:0]  byte_count,
    input  wire logic        last_word,
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      digest_word,
    output logic             last_result,
    output logic             error,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    b2b_pkg::cmd_t in_cmd, q_cmd;
    b2b_pkg::res_t res_in, res_out;
    logic          cmd_empty, cmd_pop, res_push, res_full;
    logic [$bits(b2b_pkg::cmd_t)-1:0] q_bits;
    logic [$bits(b2b_pkg::res_t)-1:0] r_bits;

    assign cfg_ready = 1'b1;

    b2b_front u_front (
        .data_word (data_word),
        .byte_count(byte_count),
        .last_word (last_word),
        .cmd       (in_cmd)
    );

    // Item queue between front and back
    b2b_fifo #(.WIDTH($bits(b2b_pkg::cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (push),
        .wr_data(in_cmd),
        .full   (full),
        .rd_en  (cmd_pop),
        .rd_data(q_bits),
        .empty  (cmd_empty)
    );
    assign q_cmd = b2b_pkg::cmd_t'(q_bits);

    b2b_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (q_cmd),
        .cmd_empty(cmd_empty),
        .cmd_pop  (cmd_pop),
        .res_data (res_in),
        .res_push (res_push),
        .res_full (res_full),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Result queue
    b2b_fifo #(.WIDTH($bits(b2b_pkg::res_t)), .DEPTH(RES_DEPTH)) u_res_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (res_push),
        .wr_data(res_in),
        .full   (res_full),
        .rd_en  (pop),
        .rd_data(r_bits),
        .empty  (empty)
    );
    assign res_out     = b2b_pkg::res_t'(r_bits);
    assign digest_word = res_out.digest;
    assign last_result = res_out.last;
    assign error       = res_out.err;

endmodule
`default_nettype wire

// ----- design/b2b_fifo.sv -----
// Small register queue used between the engine stages.
`default_nettype none
module b2b_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// ----- design/b2b_front.sv -----
// Front end: classifies each input item and cleans its payload.
`default_nettype none
module b2b_front (
    input  wire logic [63:0] data_word,
    input  wire logic [3:0]  byte_count,
    input  wire logic        last_word,
    output b2b_pkg::cmd_t    cmd
);
    logic [3:0] cnt;

    // Counts above eight mean a full word
    assign cnt = (byte_count > 4'd8) ? 4'd8 : byte_count;

    always_comb
    begin
        cmd.count = cnt;
        cmd.last  = last_word;
        // short word in the middle of a message is rejected
        cmd.err   = !last_word && (cnt != 4'd8);
        cmd.word  = b2b_pkg::keep_bytes(data_word, cnt);
    end

endmodule
`default_nettype wire

// ----- design/b2b_core.sv -----
// Back end: block buffer, compression sequencer and digest output.
`default_nettype none
module b2b_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire b2b_pkg::cmd_t cmd,
    input  wire logic          cmd_empty,
    output logic               cmd_pop,
    output b2b_pkg::res_t      res_data,
    output logic               res_push,
    input  wire logic          res_full,
    input  wire logic          cfg_valid,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [63:0]   cfg_data
);
    typedef enum logic [6:0] {
        ST_INIT   = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_PREP   = 7'b0000100,
        ST_LOAD   = 7'b0001000,
        ST_ROUND  = 7'b0010000,
        ST_FINISH = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [6:0]      digest_len_reg, digest_len_next;
    logic [6:0]      key_len_reg, key_len_next;
    logic [63:0]     salt_low_reg, salt_low_next;
    logic [63:0]     salt_high_reg, salt_high_next;
    logic [63:0]     pers_low_reg, pers_low_next;
    logic [63:0]     pers_high_reg, pers_high_next;
    logic [63:0]     chain_reg [8];
    logic [63:0]     chain_next [8];
    logic [63:0]     v_reg [16];
    logic [63:0]     v_next [16];
    logic [63:0]     buf_reg [16];
    logic [63:0]     buf_next [16];
    logic [63:0]     cnt_lo_reg, cnt_lo_next;
    logic [63:0]     cnt_hi_reg, cnt_hi_next;
    logic [7:0]      buffered_reg, buffered_next;
    logic            final_reg, final_next;
    logic [3:0]      round_reg, round_next;
    logic [3:0]      sig_reg, sig_next;
    logic [3:0]      step_reg, step_next;
    logic [2:0]      emit_reg, emit_next;

    b2b_pkg::g_idx_t gi;
    logic [3:0]      msg_idx;
    logic [4:0]      words_used;
    logic [7:0]      used_sum;
    logic [63:0]     msg;
    logic [63:0]     ga, gb, gc, gd, a1, b1, c1, d1;
    logic [64:0]     lo_sum;
    logic [6:0]      dl_eff, kl_eff, rem;
    logic [6:0]      nw_sum;
    logic [3:0]      nwords;
    logic [63:0]     p0;

    // Effective lengths and parameter block word
    assign dl_eff = (digest_len_reg == 7'd0) ? 7'd1 :
                    (digest_len_reg > 7'd64) ? 7'd64 : digest_len_reg;
    assign kl_eff = (key_len_reg > 7'd64) ? 7'd64 : key_len_reg;
    assign p0     = {32'd0, 8'd1, 8'd1, 1'b0, kl_eff, 1'b0, dl_eff};
    assign nw_sum = dl_eff + 7'd7;
    assign nwords = nw_sum[6:3];
    assign rem    = dl_eff - {1'b0, emit_reg, 3'b000};

    // Message word for the current half step; slots past the data read as zero
    assign used_sum   = buffered_reg + 8'd7;
    assign words_used = used_sum[7:3];
    assign gi         = b2b_pkg::g_index(step_reg[3:1]);
    assign msg_idx    = b2b_pkg::SIGMA[sig_reg][step_reg];
    assign msg        = ({1'b0, msg_idx} < words_used) ? buf_reg[msg_idx] : 64'd0;

    // Half of a G function per cycle
    always_comb
    begin
        ga = v_reg[gi.a];
        gb = v_reg[gi.b];
        gc = v_reg[gi.c];
        gd = v_reg[gi.d];
        a1 = ga + gb + msg;
        if (!step_reg[0])
        begin
            d1 = b2b_pkg::rotr(gd ^ a1, 32);
            c1 = gc + d1;
            b1 = b2b_pkg::rotr(gb ^ c1, 24);
        end
        else
        begin
            d1 = b2b_pkg::rotr(gd ^ a1, 16);
            c1 = gc + d1;
            b1 = b2b_pkg::rotr(gb ^ c1, 63);
        end
    end

    assign lo_sum = {1'b0, cnt_lo_reg} + {57'd0, buffered_reg};

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        digest_len_next = digest_len_reg;
        key_len_next    = key_len_reg;
        salt_low_next   = salt_low_reg;
        salt_high_next  = salt_high_reg;
        pers_low_next   = pers_low_reg;
        pers_high_next  = pers_high_reg;
        chain_next      = chain_reg;
        v_next          = v_reg;
        buf_next        = buf_reg;
        cnt_lo_next     = cnt_lo_reg;
        cnt_hi_next     = cnt_hi_reg;
        buffered_next   = buffered_reg;
        final_next      = final_reg;
        round_next      = round_reg;
        sig_next        = sig_reg;
        step_next       = step_reg;
        emit_next       = emit_reg;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res_data        = '0;

        unique case (state_reg)
            ST_INIT:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = b2b_pkg::IV[i];
                end
                chain_next[0] = b2b_pkg::IV[0] ^ p0;
                chain_next[4] = b2b_pkg::IV[4] ^ salt_low_reg;
                chain_next[5] = b2b_pkg::IV[5] ^ salt_high_reg;
                chain_next[6] = b2b_pkg::IV[6] ^ pers_low_reg;
                chain_next[7] = b2b_pkg::IV[7] ^ pers_high_reg;
                cnt_lo_next   = '0;
                cnt_hi_next   = '0;
                buffered_next = '0;
                state_next    = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    if (cmd.err)
                    begin
                        if (!res_full)
                        begin
                            res_push     = 1'b1;
                            res_data.err = 1'b1;
                            cmd_pop      = 1'b1;
                        end
                    end
                    else if ((cmd.count != 4'd0) && (buffered_reg == b2b_pkg::BLOCK_BYTES))
                    begin
                        // full block waits until more data shows up
                        final_next = 1'b0;
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        cmd_pop = 1'b1;
                        if (cmd.count != 4'd0)
                        begin
                            buf_next[buffered_reg[6:3]] = cmd.word;
                            buffered_next = buffered_reg + {4'd0, cmd.count};
                        end
                        if (cmd.last)
                        begin
                            final_next = 1'b1;
                            state_next = ST_PREP;
                        end
                    end
                end
            end
            ST_PREP:
            begin
                // advance the 128-bit byte counter
                cnt_lo_next = lo_sum[63:0];
                cnt_hi_next = cnt_hi_reg + {63'd0, lo_sum[64]};
                state_next  = ST_LOAD;
            end
            ST_LOAD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v_next[i]     = chain_reg[i];
                    v_next[i + 8] = b2b_pkg::IV[i];
                end
                v_next[12] = b2b_pkg::IV[4] ^ cnt_lo_reg;
                v_next[13] = b2b_pkg::IV[5] ^ cnt_hi_reg;
                v_next[14] = final_reg ? ~b2b_pkg::IV[6] : b2b_pkg::IV[6];
                round_next = '0;
                sig_next   = '0;
                step_next  = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                v_next[gi.a] = a1;
                v_next[gi.b] = b1;
                v_next[gi.c] = c1;
                v_next[gi.d] = d1;
                step_next    = step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    round_next = round_reg + 4'd1;
                    sig_next   = (sig_reg == 4'd9) ? 4'd0 : sig_reg + 4'd1;
                    if (round_reg == 4'(b2b_pkg::ROUNDS - 1))
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] ^ v_reg[i] ^ v_reg[i + 8];
                end
                if (final_reg)
                begin
                    emit_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    buffered_next = '0;
                    state_next    = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!res_full)
                begin
                    res_push        = 1'b1;
                    res_data.digest = (rem < 7'd8) ?
                        b2b_pkg::keep_bytes(chain_reg[emit_reg], rem[3:0]) :
                        chain_reg[emit_reg];
                    res_data.last   = ({1'b0, emit_reg} == (nwords - 4'd1));
                    emit_next       = emit_reg + 3'd1;
                    if ({1'b0, emit_reg} == (nwords - 4'd1))
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase

        // Register writes restart the engine with the new parameters
        if (cfg_valid)
        begin
            unique case (cfg_index)
                b2b_pkg::CFG_DIGEST_LEN:    digest_len_next = cfg_data[6:0];
                b2b_pkg::CFG_KEY_LEN:       key_len_next    = cfg_data[6:0];
                b2b_pkg::CFG_SALT_LOW:      salt_low_next   = cfg_data;
                b2b_pkg::CFG_SALT_HIGH:     salt_high_next  = cfg_data;
                b2b_pkg::CFG_PERSONAL_LOW:  pers_low_next   = cfg_data;
                b2b_pkg::CFG_PERSONAL_HIGH: pers_high_next  = cfg_data;
                default:                    ;
            endcase
            if (cfg_index <= b2b_pkg::CFG_PERSONAL_HIGH)
            begin
                state_next = ST_INIT;
            end
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            digest_len_reg <= 7'd64;
            key_len_reg    <= 7'd0;
            salt_low_reg   <= '0;
            salt_high_reg  <= '0;
            pers_low_reg   <= '0;
            pers_high_reg  <= '0;
            cnt_lo_reg     <= '0;
            cnt_hi_reg     <= '0;
            buffered_reg   <= '0;
            final_reg      <= 1'b0;
            round_reg      <= '0;
            sig_reg        <= '0;
            step_reg       <= '0;
            emit_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            digest_len_reg <= digest_len_next;
            key_len_reg    <= key_len_next;
            salt_low_reg   <= salt_low_next;
            salt_high_reg  <= salt_high_next;
            pers_low_reg   <= pers_low_next;
            pers_high_reg  <= pers_high_next;
            cnt_lo_reg     <= cnt_lo_next;
            cnt_hi_reg     <= cnt_hi_next;
            buffered_reg   <= buffered_next;
            final_reg      <= final_next;
            round_reg      <= round_next;
            sig_reg        <= sig_next;
            step_reg       <= step_next;
            emit_reg       <= emit_next;
        end
    end

    // Datapath storage
    always_ff @(posedge clk)
    begin
        chain_reg <= chain_next;
        v_reg     <= v_next;
        buf_reg   <= buf_next;
    end

    // Checks
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full) else $error("result pushed into full queue");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty) else $error("item popped from empty queue");
    a_buf_limit: assert property (@(posedge clk) disable iff (!rst_n)
        buffered_reg <= b2b_pkg::BLOCK_BYTES) else $error("block buffer overrun");
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (round_reg < 4'(b2b_pkg::ROUNDS) && sig_reg < 4'd10))
        else $error("round counter out of range");
    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> ({1'b0, emit_reg} < nwords))
        else $error("too many digest words");

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the BLAKE2b hash engine: digest prediction, random traffic, stalls.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Expected result item
    typedef struct {
        logic [63:0] digest;
        logic        last;
        logic        err;
    } digest_item_t;

    // Digest predictor and store of expected result items
    class digest_board;
        logic [63:0] cfg_regs [0:5];
        logic [63:0] chain [0:7];
        logic [63:0] buf_words [0:15];
        logic [63:0] cnt_lo, cnt_hi;
        int unsigned buf_bytes;
        digest_item_t pending [$];
        int unsigned mismatches;

        function void reset_regs();
            cfg_regs[0] = 64;
            for (int i = 1; i < 6; i++)
            begin
                cfg_regs[i] = '0;
            end
            restart();
        endfunction

        function int unsigned digest_bytes();
            if (cfg_regs[0] == 0) return 1;
            if (cfg_regs[0] > 64) return 64;
            return 32'(cfg_regs[0]);
        endfunction

        function void restart();
            logic [63:0] klen;
            klen = (cfg_regs[1] > 64) ? 64'd64 : cfg_regs[1];
            for (int i = 0; i < 8; i++)
            begin
                chain[i] = b2b_pkg::IV[i];
            end
            chain[0] ^= 64'(digest_bytes()) | (klen << 8) | (64'd1 << 16) | (64'd1 << 24);
            chain[4] ^= cfg_regs[2];
            chain[5] ^= cfg_regs[3];
            chain[6] ^= cfg_regs[4];
            chain[7] ^= cfg_regs[5];
            cnt_lo = '0;
            cnt_hi = '0;
            for (int i = 0; i < 16; i++)
            begin
                buf_words[i] = '0;
            end
            buf_bytes = 0;
        endfunction

        function void write_reg(int unsigned idx, logic [63:0] val);
            if (idx > 5) return;
            cfg_regs[idx] = (idx < 2) ? (val & 64'h7f) : val;
            restart();
        endfunction

        function void advance(logic [63:0] n);
            cnt_lo += n;
            if (cnt_lo < n) cnt_hi += 1;
        endfunction

        function logic [63:0] ror(logic [63:0] x, int n);
            return (x >> n) | (x << (64 - n));
        endfunction

        function void mix_g(ref logic [63:0] v [0:15], input int a, int b, int c, int d,
                            input logic [63:0] x, logic [63:0] y);
            v[a] = v[a] + v[b] + x;
            v[d] = ror(v[d] ^ v[a], 32);
            v[c] = v[c] + v[d];
            v[b] = ror(v[b] ^ v[c], 24);
            v[a] = v[a] + v[b] + y;
            v[d] = ror(v[d] ^ v[a], 16);
            v[c] = v[c] + v[d];
            v[b] = ror(v[b] ^ v[c], 63);
        endfunction

        function void compress_block(bit is_final);
            logic [63:0] v [0:15];
            logic [63:0] m [0:15];
            int s;
            for (int i = 0; i < 8; i++)
            begin
                v[i] = chain[i];
                v[i + 8] = b2b_pkg::IV[i];
            end
            v[12] ^= cnt_lo;
            v[13] ^= cnt_hi;
            if (is_final) v[14] = ~v[14];
            for (int r = 0; r < 12; r++)
            begin
                s = r % 10;
                // message words in this round's order
                for (int j = 0; j < 16; j++)
                begin
                    m[j] = buf_words[b2b_pkg::SIGMA[s][j]];
                end
                mix_g(v, 0, 4, 8, 12, m[0], m[1]);
                mix_g(v, 1, 5, 9, 13, m[2], m[3]);
                mix_g(v, 2, 6, 10, 14, m[4], m[5]);
                mix_g(v, 3, 7, 11, 15, m[6], m[7]);
                mix_g(v, 0, 5, 10, 15, m[8], m[9]);
                mix_g(v, 1, 6, 11, 12, m[10], m[11]);
                mix_g(v, 2, 7, 8, 13, m[12], m[13]);
                mix_g(v, 3, 4, 9, 14, m[14], m[15]);
            end
            for (int i = 0; i < 8; i++)
            begin
                chain[i] ^= v[i] ^ v[i + 8];
            end
        endfunction

        // Note one accepted message word; queue the result items it causes
        function void note_word(logic [63:0] w, logic [3:0] bc, logic lw);
            int unsigned cnt, dl, nw, rem;
            digest_item_t it;
            cnt = (bc > 8) ? 8 : bc;
            if (!lw && cnt < 8)
            begin
                it = '{64'd0, 1'b0, 1'b1};
                pending.push_back(it);
                return;
            end
            if (cnt > 0)
            begin
                if (buf_bytes >= 128)
                begin
                    advance(128);
                    compress_block(0);
                    buf_bytes = 0;
                end
                if (cnt < 8) w &= (64'd1 << (8 * cnt)) - 1;
                buf_words[(buf_bytes >> 3) & 15] = w;
                buf_bytes += cnt;
            end
            if (!lw) return;
            for (int k = (buf_bytes + 7) >> 3; k < 16; k++)
            begin
                buf_words[k] = '0;
            end
            advance(buf_bytes);
            compress_block(1);
            dl = digest_bytes();
            nw = (dl + 7) >> 3;
            for (int k = 0; k < nw; k++)
            begin
                it.digest = chain[k];
                rem = dl - 8 * k;
                if (rem < 8) it.digest &= (64'd1 << (8 * rem)) - 1;
                it.last = (k + 1 == nw);
                it.err = 1'b0;
                pending.push_back(it);
            end
            restart();
        endfunction

        // Compare one accepted result item with the oldest expectation
        function void check_result(logic [63:0] d, logic l, logic e);
            digest_item_t x;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h %b %b", d, l, e);
                return;
            end
            x = pending.pop_front();
            if (d !== x.digest || l !== x.last || e !== x.err)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %h last %b err %b, got %h last %b err %b",
                             x.digest, x.last, x.err, d, l, e);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        push = 0;
    logic [63:0] data_word = '0;
    logic [3:0]  byte_count = '0;
    logic        last_word = 0;
    logic        pop = 0;
    logic        cfg_valid = 0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    wire         full, empty, last_result, error, cfg_ready;
    wire  [63:0] digest_word;

    digest_board board;
    int unsigned send_idle_pct, recv_idle_pct;

    blake2b_hash_engine dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .data_word(data_word),
        .byte_count(byte_count), .last_word(last_word), .empty(empty), .pop(pop),
        .digest_word(digest_word), .last_result(last_result), .error(error),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Run limit: reports failure if the run has not ended; long messages take one compression per block plus stalls
    initial
    begin
        #20ms;
        $display("blake2b_hash_engine verification failed");
        $finish;
    end

    // Result side: random pop, check on accept
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty) board.check_result(digest_word, last_result, error);
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Send one message word, with random idle cycles before it
    task automatic send_word(logic [63:0] w, logic [3:0] bc, logic lw);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 0;
            @(posedge clk);
        end
        push <= 1;
        data_word <= w;
        byte_count <= bc;
        last_word <= lw;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        board.note_word(w, bc, lw);
    endtask

    // Wait for all expected items, then let a possible compression finish
    task automatic drain();
        push <= 0;
        while (board.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (400) @(posedge clk);
    endtask

    task automatic write_cfg(b2b_pkg::cfg_idx_t idx, logic [63:0] val);
        drain();
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        board.write_reg(idx, val);
        cfg_valid <= 0;
    endtask

    // Message of nbytes in full words with a final last word of the remaining 0 to 8 bytes
    task automatic send_message(int unsigned nbytes);
        int unsigned left;
        left = nbytes;
        while (left > 8)
        begin
            send_word({$urandom, $urandom}, 4'd8, 1'b0);
            left -= 8;
        end
        send_word({$urandom, $urandom}, 4'(left), 1'b1);
    endtask

    // Keyed message: zero-padded key block first
    task automatic send_keyed(int unsigned klen, int unsigned nbytes);
        logic [63:0] w;
        for (int i = 0; i < 16; i++)
        begin
            w = {$urandom, $urandom};
            if (8 * i >= klen) w = '0;
            send_word(w, 4'd8, 1'b0);
        end
        send_message(nbytes);
    endtask

    initial
    begin
        int unsigned sz;
        board = new();
        board.reset_regs();
        send_idle_pct = 6;
        recv_idle_pct = 47;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // Directed: empty message, field extremes, short words, odd counts
        send_word(64'hffff_ffff_ffff_ffff, 4'd0, 1'b1);
        send_word(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1);
        send_word(64'h0, 4'd15, 1'b1);
        send_word(64'hffff_ffff_ffff_ffff, 4'd3, 1'b0);
        send_word(64'h1234_5678_9abc_def0, 4'd0, 1'b0);
        send_word(64'hffff_ffff_ffff_ffff, 4'd9, 1'b0);
        send_word(64'hdead_beef_cafe_f00d, 4'd5, 1'b1);
        send_message(128);
        send_message(129);
        write_cfg(b2b_pkg::CFG_DIGEST_LEN, 64'd1);
        send_message(3);
        write_cfg(b2b_pkg::CFG_DIGEST_LEN, 64'd0);
        send_message(8);
        write_cfg(b2b_pkg::CFG_DIGEST_LEN, 64'd127);
        send_message(17);
        write_cfg(b2b_pkg::CFG_SALT_LOW, 64'hffff_ffff_ffff_ffff);
        write_cfg(b2b_pkg::CFG_SALT_HIGH, 64'h0123_4567_89ab_cdef);
        write_cfg(b2b_pkg::CFG_PERSONAL_LOW, 64'hffff_ffff_ffff_ffff);
        write_cfg(b2b_pkg::CFG_PERSONAL_HIGH, 64'hfedc_ba98_7654_3210);
        write_cfg(b2b_pkg::CFG_KEY_LEN, 64'd64);
        send_keyed(64, 40);
        write_cfg(b2b_pkg::CFG_KEY_LEN, 64'd127);
        send_message(9);
        // Index past the register list does nothing
        write_cfg(b2b_pkg::cfg_idx_t'(3'd6), 64'd5);
        send_message(16);

        // Random phases: configuration, then messages; idling schedule changes
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 6;
            end
            if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_cfg(b2b_pkg::CFG_DIGEST_LEN, 64'($urandom_range(64, 1)));
            write_cfg(b2b_pkg::CFG_KEY_LEN, 64'($urandom_range(64)));
            write_cfg(b2b_pkg::cfg_idx_t'(3'($urandom_range(5, 2))), {$urandom, $urandom});
            for (int m = 0; m < 3; m++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    send_keyed($urandom_range(64, 1), $urandom_range(24));
                end
                else
                begin
                    sz = ($urandom_range(7) == 0) ? $urandom_range(300) : $urandom_range(40);
                    send_message(sz);
                end
                // Noise: a short non-last word, random content
                if ($urandom_range(2) == 0)
                    send_word({$urandom, $urandom}, 4'($urandom_range(7)), 1'b0);
                // Noise: arbitrary fields
                if ($urandom_range(3) == 0)
                    send_word({$urandom, $urandom}, 4'($urandom), 1'($urandom));
            end
        end

        drain();
        if (board.mismatches == 0 && board.pending.size() == 0)
        begin
            $display("blake2b_hash_engine verification clean");
        end
        else
        begin
            $display("blake2b_hash_engine verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
